// File: rtl/ctm_pkg.sv
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types and constants of the TCP connection state tracker.
// ----------------------------------------------------------------------------
package ctm_pkg;

  localparam int unsigned KEY_W = 96;
  localparam int unsigned ENT_W = 36;

  localparam logic [15:0] MIN_SEGMENT = 16'd20;

  localparam int unsigned FLAG_FIN_BIT = 0;
  localparam int unsigned FLAG_SYN_BIT = 1;
  localparam int unsigned FLAG_ACK_BIT = 4;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLOSED       = 4'd0,
    ST_LISTEN       = 4'd1,
    ST_SYN_SENT     = 4'd2,
    ST_SYN_RECEIVED = 4'd3,
    ST_ESTABLISHED  = 4'd4,
    ST_FIN_WAIT_1   = 4'd5,
    ST_FIN_WAIT_2   = 4'd6,
    ST_CLOSE_WAIT   = 4'd7,
    ST_CLOSING      = 4'd8,
    ST_LAST_ACK     = 4'd9,
    ST_TIME_WAIT    = 4'd10
  } conn_state_e;

  typedef struct packed {
    logic done;
    logic hit;
    logic full;
  } scan_res_t;

  typedef struct packed {
    logic        start;
    logic        created;
    logic [31:0] seq;
    logic [7:0]  flags;
  } upd_req_t;

  typedef struct packed {
    logic        done;
    conn_state_e state;
    logic [31:0] ack;
  } upd_res_t;

endpackage

// File: rtl/ctm_key_scan.sv
// ----------------------------------------------------------------------------
// ctm_key_scan
// Connection key memory with fill count; scans filled slots for a match and
// appends new keys at the fill count.
// ----------------------------------------------------------------------------
module ctm_key_scan
  import ctm_pkg::*;
#(
  parameter int unsigned Entries = 16,
  parameter int unsigned IdxW    = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             ins_i,
  output scan_res_t        res_o,
  output logic [IdxW-1:0]  slot_o
);

  localparam int unsigned Depth = 1 << IdxW;

  logic [KEY_W-1:0] mem [Depth];
  logic [KEY_W-1:0] rdata_q;
  logic [KEY_W-1:0] key_q;
  logic             busy_q;
  logic             pend_q;
  logic [IdxW-1:0]  pend_idx_q;
  logic [IdxW:0]    issue_q;
  logic [IdxW:0]    count_q;
  logic             match;
  logic             more;

  assign match = pend_q && (rdata_q == key_q);
  assign more  = issue_q < count_q;

  always_comb begin
    res_o      = '0;
    res_o.full = (count_q == (IdxW + 1)'(Entries));
    slot_o     = count_q[IdxW-1:0];
    if (busy_q) begin
      if (match) begin
        res_o.done = 1'b1;
        res_o.hit  = 1'b1;
        slot_o     = pend_idx_q;
      end else if (!more) begin
        res_o.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      issue_q    <= '0;
      count_q    <= '0;
    end else begin
      if (start_i) begin
        busy_q  <= 1'b1;
        pend_q  <= 1'b0;
        issue_q <= '0;
      end else if (busy_q) begin
        if (match || !more) begin
          busy_q <= 1'b0;
          pend_q <= 1'b0;
        end else begin
          pend_q     <= 1'b1;
          pend_idx_q <= issue_q[IdxW-1:0];
          issue_q    <= issue_q + 1'b1;
        end
      end
      if (ins_i) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[issue_q[IdxW-1:0]];
    if (start_i) begin
      key_q <= key_i;
    end
    if (ins_i) begin
      mem[count_q[IdxW-1:0]] <= key_q;
    end
  end

endmodule

// File: rtl/ctm_conn_update.sv
// ----------------------------------------------------------------------------
// ctm_conn_update
// Connection state memory; read-modify-write of one slot per request,
// applying SYN, ACK and FIN in that order.
// ----------------------------------------------------------------------------
module ctm_conn_update
  import ctm_pkg::*;
#(
  parameter int unsigned IdxW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  upd_req_t        req_i,
  input  logic [IdxW-1:0] slot_i,
  output upd_res_t        res_o
);

  localparam int unsigned Depth = 1 << IdxW;

  logic [ENT_W-1:0] mem [Depth];
  logic [ENT_W-1:0] rdata_q;
  logic             rd_q;
  logic             created_q;
  logic [31:0]      seq_q;
  logic [7:0]       flags_q;
  logic [IdxW-1:0]  slot_q;
  conn_state_e      st;
  logic [31:0]      ack;

  always_comb begin
    if (created_q) begin
      st  = ST_CLOSED;
      ack = '0;
    end else begin
      st  = conn_state_e'(rdata_q[ENT_W-1:32]);
      ack = rdata_q[31:0];
    end
    if (flags_q[FLAG_SYN_BIT] && (st == ST_CLOSED || st == ST_LISTEN)) begin
      st  = ST_SYN_RECEIVED;
      ack = seq_q + 32'd1;
    end
    if (flags_q[FLAG_ACK_BIT] && st == ST_SYN_RECEIVED) begin
      st = ST_ESTABLISHED;
    end
    if (flags_q[FLAG_FIN_BIT] && st == ST_ESTABLISHED) begin
      st  = ST_CLOSE_WAIT;
      ack = seq_q + 32'd1;
    end
    res_o.done  = rd_q;
    res_o.state = st;
    res_o.ack   = ack;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
    end else begin
      rd_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[slot_i];
    if (req_i.start) begin
      created_q <= req_i.created;
      seq_q     <= req_i.seq;
      flags_q   <= req_i.flags;
      slot_q    <= slot_i;
    end
    if (rd_q) begin
      mem[slot_q] <= {st, ack};
    end
  end

endmodule

// File: rtl/tcp_connection_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker
// Tracks TCP connection state per four-tuple in a bounded table.
// ----------------------------------------------------------------------------
// One segment request is processed at a time and yields one result. A segment
// under 20 bytes gets a short-segment result without a table lookup. Otherwise
// the key memory is scanned one filled slot per cycle (one read port, registered
// read), then the state memory slot is read, updated and written back. At most
// TABLE_ENTRIES slots are filled; a request with no match on a full table is
// refused. Slots are filled in order and never freed until reset; no clearing
// pass is needed. A finished result waits in the output register while the
// next request is taken.
module tcp_connection_state_tracker
  import ctm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] dst_port_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  input  logic [31:0] sequence_number_i,
  input  logic [7:0]  tcp_flags_i,
  input  logic [15:0] segment_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic        created_o,
  output logic [3:0]  conn_state_o,
  output logic [31:0] ack_value_o
);

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SlotW = (IdxW > 4) ? IdxW : 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_OUT
  } ctl_state_e;

  ctl_state_e       state_q;
  logic             in_accept;
  logic             is_short;
  logic             scan_start;
  logic             ins;
  scan_res_t        scan_res;
  logic [IdxW-1:0]  scan_slot;
  upd_req_t         upd_req;
  upd_res_t         upd_res;
  logic [31:0]      seq_q;
  logic [7:0]       flags_q;
  logic [IdxW-1:0]  slot_q;
  logic             created_q;
  status_e          res_status_q;
  conn_state_e      res_state_q;
  logic [31:0]      res_ack_q;
  logic             out_valid_q;
  logic             out_load;
  logic [SlotW-1:0] slot_ext;
  logic [1:0]       status_q;
  logic [3:0]       slot_out_q;
  logic             created_out_q;
  logic [3:0]       conn_state_q;
  logic [31:0]      ack_out_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_short   = segment_length_i < MIN_SEGMENT;
  assign scan_start = in_accept && !is_short;
  assign ins        = (state_q == S_SCAN) && scan_res.done && !scan_res.hit && !scan_res.full;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign slot_ext   = SlotW'(slot_q);

  always_comb begin
    upd_req.start   = (state_q == S_SCAN) && scan_res.done && (scan_res.hit || !scan_res.full);
    upd_req.created = !scan_res.hit;
    upd_req.seq     = seq_q;
    upd_req.flags   = flags_q;
  end

  ctm_key_scan #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IdxW)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   ({dest_address_i, source_address_i, dst_port_i, source_port_i}),
    .ins_i   (ins),
    .res_o   (scan_res),
    .slot_o  (scan_slot)
  );

  ctm_conn_update #(
    .IdxW (IdxW)
  ) u_upd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (upd_req),
    .slot_i (scan_slot),
    .res_o  (upd_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      seq_q         <= '0;
      flags_q       <= '0;
      slot_q        <= '0;
      created_q     <= 1'b0;
      res_status_q  <= STATUS_OK;
      res_state_q   <= ST_CLOSED;
      res_ack_q     <= '0;
      status_q      <= '0;
      slot_out_q    <= '0;
      created_out_q <= 1'b0;
      conn_state_q  <= '0;
      ack_out_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            seq_q   <= sequence_number_i;
            flags_q <= tcp_flags_i;
            if (is_short) begin
              res_status_q <= STATUS_SHORT;
              slot_q       <= '0;
              created_q    <= 1'b0;
              res_state_q  <= ST_CLOSED;
              res_ack_q    <= '0;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.hit || !scan_res.full) begin
              slot_q    <= scan_slot;
              created_q <= !scan_res.hit;
              state_q   <= S_UPD;
            end else begin
              res_status_q <= STATUS_FULL;
              slot_q       <= '0;
              created_q    <= 1'b0;
              res_state_q  <= ST_CLOSED;
              res_ack_q    <= '0;
              state_q      <= S_OUT;
            end
          end
        end
        S_UPD: begin
          if (upd_res.done) begin
            res_status_q <= STATUS_OK;
            res_state_q  <= upd_res.state;
            res_ack_q    <= upd_res.ack;
            state_q      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            status_q      <= res_status_q;
            slot_out_q    <= slot_ext[3:0];
            created_out_q <= created_q;
            conn_state_q  <= res_state_q;
            ack_out_q     <= res_ack_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_out_q;
  assign created_o    = created_out_q;
  assign conn_state_o = conn_state_q;
  assign ack_value_o  = ack_out_q;

endmodule

// File: rtl/ctm_checker.sv
// ----------------------------------------------------------------------------
// ctm_checker
// Port-level checks of the connection tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ctm_checker
  import ctm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] dest_address_i,
  input logic [15:0] dst_port_i,
  input logic [31:0] source_address_i,
  input logic [15:0] source_port_i,
  input logic [31:0] sequence_number_i,
  input logic [7:0]  tcp_flags_i,
  input logic [15:0] segment_length_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [3:0]  slot_index_o,
  input logic        created_o,
  input logic [3:0]  conn_state_o,
  input logic [31:0] ack_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(slot_index_o) && $stable(created_o) && $stable(conn_state_o) &&
      $stable(ack_value_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one in progress");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> slot_index_o == 4'd0 && !created_o &&
      conn_state_o == ST_CLOSED && ack_value_o == 32'd0)
    else $error("error result carries nonzero fields");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && created_o |-> status_o == STATUS_OK &&
      (conn_state_o == ST_CLOSED || conn_state_o == ST_SYN_RECEIVED ||
       conn_state_o == ST_ESTABLISHED || conn_state_o == ST_CLOSE_WAIT))
    else $error("new entry with bad status or state");

endmodule

bind tcp_connection_state_tracker ctm_checker u_ctm_checker (.*);

// File: tb/tcp_connection_state_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_connection_state_tracker_tb
// Self-checking testbench for the TCP connection state tracker.
// A table of directed segments covers short segments, the SYN/ACK/FIN
// handshake, flags with no transition, key fields that differ by one field,
// and filling the table until a new connection is refused. A random run
// follows: mostly well-formed flag sequences on known connections, with
// near-miss keys, fresh keys, short segments and random flags mixed in. Every
// result is checked field by field against the row's expected result or a mirror of the connection table.
// ----------------------------------------------------------------------------
module tcp_connection_state_tracker_tb
  import ctm_pkg::*;
();

  localparam int unsigned TABLE_SIZE    = 16;
  localparam int          RANDOM_ITEMS  = 1924;
  localparam int          MAX_WAIT      = 18;
  localparam int          TAIL_CYCLES   = 40;
  localparam int          CYCLE_LIMIT   = 600_000;

  localparam logic [7:0] FLAG_FIN      = 8'd1 << FLAG_FIN_BIT;
  localparam logic [7:0] FLAG_SYN      = 8'd1 << FLAG_SYN_BIT;
  localparam logic [7:0] FLAG_ACK      = 8'd1 << FLAG_ACK_BIT;
  localparam logic [7:0] TRACKED_FLAGS = FLAG_FIN | FLAG_SYN | FLAG_ACK;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [15:0] dst_port;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] length;
  } segment_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    logic        created;
    conn_state_e state;
    logic [31:0] ack;
  } verdict_t;

  typedef struct packed {
    logic     fresh;  // tuple drawn at random when the row is sent
    logic     typed;  // want holds the expected result
    segment_t seg;
    verdict_t want;
  } row_t;

  localparam verdict_t BY_MODEL = '{STATUS_OK, 4'd0, 1'b0, ST_CLOSED, 32'd0};
  localparam verdict_t SHORT_VERDICT = '{STATUS_SHORT, 4'd0, 1'b0, ST_CLOSED, 32'd0};

  localparam int DIRECTED_ROWS = 26;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 1'b1, '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                    32'hFFFF_FFFF, 8'hFF, 16'd0}, SHORT_VERDICT},
    '{1'b0, 1'b1, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'd1, FLAG_SYN, 16'd19}, SHORT_VERDICT},
    '{1'b0, 1'b1, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'd0, 8'h00, 16'd20},
      '{STATUS_OK, 4'd0, 1'b1, ST_CLOSED, 32'd0}},
    // ack wraps to zero
    '{1'b0, 1'b1, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'hFFFF_FFFF, FLAG_SYN, 16'd1500},
      '{STATUS_OK, 4'd0, 1'b0, ST_SYN_RECEIVED, 32'd0}},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'd2, FLAG_ACK, 16'd40}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'd5, FLAG_FIN, 16'd40}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'h8000_0000, 8'hFF, 16'd40}, BY_MODEL},
    // all three flags in one segment on a new connection
    '{1'b0, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0,
                    32'h10, TRACKED_FLAGS, 16'hFFFF}, BY_MODEL},
    // keys that differ from the first connection in one field each
    '{1'b0, 1'b0, '{32'hC0A8_0002, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'h7FFF_FFFF, FLAG_SYN | FLAG_ACK, 16'd60}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd443, 32'h0A00_0002, 16'hC350,
                    32'd7, FLAG_ACK, 16'd20}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0003, 16'hC350,
                    32'd9, FLAG_FIN, 16'd20}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC351,
                    32'd100, FLAG_SYN, 16'd20}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC351,
                    32'd200, FLAG_SYN, 16'd20}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC351,
                    32'd300, FLAG_FIN, 16'd20}, BY_MODEL},
    '{1'b0, 1'b0, '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                    32'h5555_AAAA, ~TRACKED_FLAGS, 16'hFFFF}, BY_MODEL},
    // fill the remaining slots
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd20}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd21}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd64}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd128}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd576}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd1460}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd4096}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd9000}, BY_MODEL},
    '{1'b1, 1'b0, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, 8'h00, 16'd32768}, BY_MODEL},
    '{1'b1, 1'b1, '{32'd0, 16'd0, 32'd0, 16'd0, 32'd0, FLAG_SYN, 16'd20},
      '{STATUS_FULL, 4'd0, 1'b0, ST_CLOSED, 32'd0}},
    // a known connection still hits with the table full
    '{1'b0, 1'b0, '{32'hC0A8_0001, 16'd80, 32'h0A00_0002, 16'hC350,
                    32'd77, TRACKED_FLAGS, 16'd20}, BY_MODEL}
  };

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_stall_o;
  logic [31:0] dest_address_i    = '0;
  logic [15:0] dst_port_i        = '0;
  logic [31:0] source_address_i  = '0;
  logic [15:0] source_port_i     = '0;
  logic [31:0] sequence_number_i = '0;
  logic [7:0]  tcp_flags_i       = '0;
  logic [15:0] segment_length_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i       = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  slot_index_o;
  logic        created_o;
  logic [3:0]  conn_state_o;
  logic [31:0] ack_value_o;

  tcp_connection_state_tracker #(.TABLE_ENTRIES(TABLE_SIZE)) dut (.*);

  // mirror of the connection table
  bit                conn_valid [TABLE_SIZE];
  logic [KEY_W-1:0]  conn_key   [TABLE_SIZE];
  conn_state_e       conn_state [TABLE_SIZE];
  logic [31:0]       conn_ack   [TABLE_SIZE];

  verdict_t pending_verdicts [$];

  int segments_sent;
  int results_checked;
  int mismatches;
  int short_seen;
  int full_seen;
  int opened;
  int syn_moves;
  int ack_moves;
  int fin_moves;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic verdict_t track_segment(segment_t seg);
    verdict_t         v;
    logic [KEY_W-1:0] key;
    int               hit;
    int               free_slot;
    conn_state_e      st;
    logic [31:0]      ack;
    v = BY_MODEL;
    key = {seg.dest_address, seg.dst_port, seg.source_address, seg.source_port};
    hit = -1;
    free_slot = -1;
    if (seg.length < MIN_SEGMENT) begin
      v.status = STATUS_SHORT;
      short_seen++;
      return v;
    end
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (conn_valid[i]) begin
        if (hit < 0 && conn_key[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        v.status = STATUS_FULL;
        full_seen++;
        return v;
      end
      hit = free_slot;
      conn_valid[hit] = 1'b1;
      conn_key[hit]   = key;
      conn_state[hit] = ST_CLOSED;
      conn_ack[hit]   = 32'd0;
      v.created = 1'b1;
      opened++;
    end
    st  = conn_state[hit];
    ack = conn_ack[hit];
    if ((seg.flags & FLAG_SYN) != 0 && (st == ST_CLOSED || st == ST_LISTEN)) begin
      ack = seg.seq + 32'd1;
      st  = ST_SYN_RECEIVED;
      syn_moves++;
    end
    if ((seg.flags & FLAG_ACK) != 0 && st == ST_SYN_RECEIVED) begin
      st = ST_ESTABLISHED;
      ack_moves++;
    end
    if ((seg.flags & FLAG_FIN) != 0 && st == ST_ESTABLISHED) begin
      st  = ST_CLOSE_WAIT;
      ack = seg.seq + 32'd1;
      fin_moves++;
    end
    conn_state[hit] = st;
    conn_ack[hit]   = ack;
    v.slot  = 4'(hit);
    v.state = st;
    v.ack   = ack;
    return v;
  endfunction

  function automatic segment_t with_random_tuple(segment_t seg);
    seg.dest_address   = $urandom();
    seg.dst_port       = 16'($urandom());
    seg.source_address = $urandom();
    seg.source_port    = 16'($urandom());
    return seg;
  endfunction

  task automatic send_segment(input segment_t seg, input logic typed, input verdict_t want);
    int       gap;
    verdict_t tracked;
    gap = ((segments_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    dest_address_i    <= seg.dest_address;
    dst_port_i        <= seg.dst_port;
    source_address_i  <= seg.source_address;
    source_port_i     <= seg.source_port;
    sequence_number_i <= seg.seq;
    tcp_flags_i       <= seg.flags;
    segment_length_i  <= seg.length;
    do @(posedge clk_i); while (in_stall_o);
    tracked = track_segment(seg);
    pending_verdicts.push_back(typed ? want : tracked);
    segments_sent++;
  endtask

  task automatic drain_pending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : stimulus
    segment_t    seg;
    row_t        row;
    int          pick;
    int unsigned slot;
    logic [7:0]  noise;
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      seg = row.fresh ? with_random_tuple(row.seg) : row.seg;
      send_segment(seg, row.typed, row.want);
    end
    drain_pending();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick      = $urandom_range(0, 99);
      slot      = $urandom_range(0, TABLE_SIZE - 1);
      seg.seq   = $urandom();
      seg.flags = 8'($urandom());
      noise     = 8'($urandom()) & ~TRACKED_FLAGS;
      seg.length = 16'($urandom_range(16'hFFFF, MIN_SEGMENT));
      {seg.dest_address, seg.dst_port, seg.source_address, seg.source_port} = conn_key[slot];
      if (!conn_valid[slot]) seg = with_random_tuple(seg);
      if (pick < 8) begin
        seg.length = 16'($urandom_range(MIN_SEGMENT - 1, 0));
        if (pick < 4) seg = with_random_tuple(seg);
      end else if (pick < 12) begin
        seg = with_random_tuple(seg);
      end else if (pick < 18) begin
        // one key bit off a known connection
        {seg.dest_address, seg.dst_port, seg.source_address, seg.source_port} =
          {seg.dest_address, seg.dst_port, seg.source_address, seg.source_port} ^
          (96'd1 << $urandom_range(KEY_W - 1, 0));
      end else if (pick < 80) begin
        case (conn_state[slot])
          ST_CLOSED, ST_LISTEN: seg.flags = FLAG_SYN | noise;
          ST_SYN_RECEIVED:      seg.flags = FLAG_ACK | noise;
          ST_ESTABLISHED:       seg.flags = FLAG_FIN | noise;
          default:              seg.flags = noise;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_pending();
      send_segment(seg, 1'b0, BY_MODEL);
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d segments, %0d results: %0d short, %0d refused on full table, %0d opened",
             segments_sent, results_checked, short_seen, full_seen, opened);
    $display("State moves: %0d on SYN, %0d on ACK, %0d on FIN; %0d mismatches",
             syn_moves, ack_moves, fin_moves, mismatches);
    if (mismatches == 0) begin
      $display("tcp_connection_state_tracker_tb: PASS");
    end else begin
      $display("tcp_connection_state_tracker_tb: FAIL");
    end
    $finish;
  end

  initial begin : result_check
    verdict_t want;
    int       stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = ((results_checked / 64) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_verdicts.size() == 0) begin
        $error("result with no request pending: status %0d slot %0d", status_o, slot_index_o);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
        check_field("created", 32'(want.created), 32'(created_o));
        check_field("conn_state", 32'(want.state), 32'(conn_state_o));
        check_field("ack_value", want.ack, ack_value_o);
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, pending_verdicts.size());
    $display("tcp_connection_state_tracker_tb: FAIL");
    $finish;
  end

endmodule
